>>> design/lmf_pkg.sv
// Shared constants and types for the grid local-minimum finder.
// No dependencies; every file of the block but lmf_ram imports this package.
package lmf_pkg;

  // Default sizes of the line buffers and the sample width
  localparam int DEF_MAX_WIDTH   = 128;
  localparam int DEF_MAX_HEIGHT  = 128;
  localparam int DEF_SAMPLE_BITS = 4;

  // Configuration port
  localparam int CFG_BITS      = 8;
  localparam int CFG_ADDR_BITS = 1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_BITS-1:0] RESET_IMAGE_WIDTH  = 8'd100;
  localparam logic [CFG_BITS-1:0] RESET_IMAGE_HEIGHT = 8'd100;

  // Result fields
  localparam int COORD_BITS      = 7;
  localparam int HEIGHT_OUT_BITS = 4;
  localparam int RISK_BITS       = 19;
  localparam int OUT_FIELD_BITS  = 2 * COORD_BITS + HEIGHT_OUT_BITS + RISK_BITS;
  localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_BITS  = 2;
  localparam int TU_IS_LOW       = 0;
  localparam int TU_FRAME_END    = 1;

  // Records pending for one sample, in the order they leave the block
  typedef struct packed {
    logic low_a;    // low point one row up, same column
    logic low_b;    // last row, previous column
    logic low_c;    // last row, this column (final sample)
    logic summary;  // frame-end record
  } lmf_flags_t;

endpackage

>>> design/lmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module lmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/lmf_window.sv
// Input register, line buffer with read-ahead, raster counters and the
// 4-neighbour compares. Uses lmf_pkg and lmf_ram.
module lmf_window #(
  parameter int MAX_WIDTH   = lmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = lmf_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = lmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]     last_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    last_row,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  input  logic                             take,
  output logic                             res_valid,
  output lmf_pkg::lmf_flags_t              res_flags,
  output logic [lmf_pkg::COORD_BITS-1:0]   row_prev,
  output logic [lmf_pkg::COORD_BITS-1:0]   row_cur,
  output logic [lmf_pkg::COORD_BITS-1:0]   col_prev,
  output logic [lmf_pkg::COORD_BITS-1:0]   col_cur,
  output logic [SAMPLE_BITS-1:0]           h_a,
  output logic [SAMPLE_BITS-1:0]           h_b,
  output logic [SAMPLE_BITS-1:0]           h_c
);
  import lmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SB = SAMPLE_BITS;
  localparam int EW = 2 * SB;   // line buffer entry: {row above, current row}

  logic          a_valid_r, a_valid_nxt;
  logic [SB-1:0] a_val_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [EW-1:0] e0_r, e1_r, e1_load;
  logic [SB-1:0] left0_r, left1_r, left2_r;
  logic [CW-1:0] rd_addr, rd_addr_q_r;
  logic [EW-1:0] ram_rd, rd_eff, wr_data, byp_data_r;
  logic          byp_r;
  logic          consume, at_last_col, at_last_row;
  logic          col_ge1, col_ge2, row_ge1, row_ge2;
  logic [SB-1:0] mid, abv, nxt, v;

  assign consume   = a_valid_r & take;
  assign in_ready  = ~a_valid_r | consume;
  assign res_valid = a_valid_r;

  assign a_valid_nxt = (in_valid & in_ready) ? 1'b1 : (consume ? 1'b0 : a_valid_r);

  assign at_last_col = (col_r == last_col);
  assign at_last_row = (row_r == last_row);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (consume) begin
      if (at_last_col) begin
        col_nxt = '0;
        row_nxt = at_last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // Fetch two columns ahead of the next sample, wrapping at the row width
  always_comb begin
    if (col_nxt == last_col) begin
      rd_addr = CW'(1);
    end else if (col_nxt + CW'(1) == last_col) begin
      rd_addr = '0;
    end else begin
      rd_addr = col_nxt + CW'(2);
    end
  end

  assign mid     = e0_r[SB-1:0];
  assign abv     = e0_r[EW-1:SB];
  assign nxt     = e1_r[SB-1:0];
  assign v       = a_val_r;
  assign wr_data = {mid, v};
  assign rd_eff  = byp_r ? byp_data_r : ram_rd;
  assign e1_load = (rd_addr_q_r == col_r) ? wr_data : rd_eff;

  lmf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (consume),
    .wr_addr (col_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      left0_r   <= '0;
      left1_r   <= '0;
      left2_r   <= '0;
      byp_r     <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      byp_r     <= consume & (rd_addr == col_r);
      if (restart) begin
        left0_r <= '0;
        left1_r <= '0;
        left2_r <= '0;
      end else if (consume) begin
        left0_r <= mid;
        left1_r <= v;
        left2_r <= left1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      a_val_r <= in_sample;
    end
    rd_addr_q_r <= rd_addr;
    byp_data_r  <= wr_data;
    if (consume) begin
      e0_r <= e1_r;
      e1_r <= e1_load;
    end
  end

  assign col_ge1 = (col_r != '0);
  assign col_ge2 = (col_r > CW'(1));
  assign row_ge1 = (row_r != '0);
  assign row_ge2 = (row_r > RW'(1));

  always_comb begin
    res_flags.low_a = row_ge1 && (v > mid) && (!row_ge2 || abv > mid) &&
                      (!col_ge1 || left0_r > mid) && (at_last_col || nxt > mid);
    // last row: the left neighbour is decided once its right neighbour is here
    res_flags.low_b = at_last_row && col_ge1 && (v > left1_r) && (left0_r > left1_r) &&
                      (!col_ge2 || left2_r > left1_r);
    res_flags.low_c = at_last_row && at_last_col && (mid > v) && (left1_r > v);
    res_flags.summary = at_last_row && at_last_col;
  end

  assign row_prev = COORD_BITS'(row_r - RW'(1));
  assign row_cur  = COORD_BITS'(row_r);
  assign col_prev = COORD_BITS'(col_r - CW'(1));
  assign col_cur  = COORD_BITS'(col_r);
  assign h_a      = mid;
  assign h_b      = left1_r;
  assign h_c      = v;

endmodule

>>> design/lmf_emit.sv
// Result queue for one sample, risk accumulator and the output register.
// Sends the pending records one a cycle while out_tready does not stall. Uses lmf_pkg.
module lmf_emit #(
  parameter int SAMPLE_BITS = lmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                res_valid,
  output logic                                take,
  input  lmf_pkg::lmf_flags_t                 res_flags,
  input  logic [lmf_pkg::COORD_BITS-1:0]      row_prev,
  input  logic [lmf_pkg::COORD_BITS-1:0]      row_cur,
  input  logic [lmf_pkg::COORD_BITS-1:0]      col_prev,
  input  logic [lmf_pkg::COORD_BITS-1:0]      col_cur,
  input  logic [SAMPLE_BITS-1:0]              h_a,
  input  logic [SAMPLE_BITS-1:0]              h_b,
  input  logic [SAMPLE_BITS-1:0]              h_c,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lmf_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic [lmf_pkg::OUT_TUSER_BITS-1:0]  out_tuser,
  output logic                                out_tlast
);
  import lmf_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int CB      = COORD_BITS;
  localparam int OUT_PAD = OUT_TDATA_BITS - OUT_FIELD_BITS;
  localparam logic [RISK_BITS-1:0] RISK_MAX = '1;

  lmf_flags_t           pend_r, pend_nxt, pend_after;
  logic [CB-1:0]        row_prev_r, row_cur_r, col_prev_r, col_cur_r;
  logic [SB-1:0]        h_a_r, h_b_r, h_c_r;
  logic [RISK_BITS-1:0] acc_r, acc_nxt, risk;
  logic [RISK_BITS:0]   risk_sum;
  logic                 pend_any, pop, load, sel_low, sel_fe;
  logic [CB-1:0]        sel_row, sel_col;
  logic [SB-1:0]        sel_h;
  logic                 out_valid_r;
  logic [OUT_TDATA_BITS-1:0] out_data_r;
  logic [OUT_TUSER_BITS-1:0] out_user_r;
  logic                 out_last_r;

  assign pend_any = |pend_r;
  assign pop      = pend_any & (~out_valid_r | out_tready);
  assign take     = ~pend_any | (pop & ~(|pend_after));
  assign load     = res_valid & take;

  // Oldest pending record first
  always_comb begin
    pend_after = pend_r;
    sel_low    = 1'b1;
    sel_fe     = 1'b0;
    sel_row    = '0;
    sel_col    = '0;
    sel_h      = '0;
    if (pend_r.low_a) begin
      pend_after.low_a = 1'b0;
      sel_row = row_prev_r;
      sel_col = col_cur_r;
      sel_h   = h_a_r;
    end else if (pend_r.low_b) begin
      pend_after.low_b = 1'b0;
      sel_row = row_cur_r;
      sel_col = col_prev_r;
      sel_h   = h_b_r;
    end else if (pend_r.low_c) begin
      pend_after.low_c = 1'b0;
      sel_row = row_cur_r;
      sel_col = col_cur_r;
      sel_h   = h_c_r;
    end else begin
      pend_after.summary = 1'b0;
      sel_low = 1'b0;
      sel_fe  = 1'b1;
    end
  end

  assign risk_sum = {1'b0, acc_r} + (RISK_BITS + 1)'(sel_h) + (RISK_BITS + 1)'(1);

  always_comb begin
    if (sel_fe) begin
      risk    = acc_r;
      acc_nxt = '0;
    end else begin
      risk    = risk_sum[RISK_BITS] ? RISK_MAX : risk_sum[RISK_BITS-1:0];
      acc_nxt = risk;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = res_flags;
    end else if (pop) begin
      pend_nxt = pend_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (restart) begin
        acc_r <= '0;
      end else if (pop) begin
        acc_r <= acc_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_prev_r <= row_prev;
      row_cur_r  <= row_cur;
      col_prev_r <= col_prev;
      col_cur_r  <= col_cur;
      h_a_r      <= h_a;
      h_b_r      <= h_b;
      h_c_r      <= h_c;
    end
    if (pop) begin
      out_data_r <= {{OUT_PAD{1'b0}}, risk, HEIGHT_OUT_BITS'(sel_h), sel_col, sel_row};
      out_user_r <= {sel_fe, sel_low};
      out_last_r <= ~(|pend_after);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

>>> design/grid_local_minimum_finder.sv
// Top level of the grid local-minimum finder: size registers, window unit
// and result emitter. Uses lmf_pkg, lmf_window and lmf_emit.
//
// Height samples stream in on in_* in raster order, one per request; a
// sample is a low point when strictly below every 4-neighbour present.
// Each low point leaves on out_* with its row, column, height and the
// running risk sum; the frame's final sample adds a frame-end record with
// the total, marked in out_tuser, and the sum restarts from zero.
// out_tlast flags the last record caused by one input sample.
// A sample is taken every cycle while it causes at most one record and out_tready
// does not stall; each extra record (a sample causes up to three) holds the input back.
// A sample's first record passes the input register, then the neighbour compares
// into the record queue, then the output register.
// A low point is decided once the sample below it arrives (last row: the
// one to its right), so results lag the input by about one row.
// A write on cfg_* sets the row width or frame height and restarts the
// frame; write only while no results are outstanding.
// Reset (rst_n low, synchronous) empties all stages, restarts the frame
// and sets both sizes to 100. A stalled out_tready holds the record; the
// queue and input register then fill and in_tready drops.
module grid_local_minimum_finder #(
  parameter int MAX_WIDTH   = lmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = lmf_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = lmf_pkg::DEF_SAMPLE_BITS,
  localparam int IN_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: height_value
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_TDATA_BITS-1:0]            in_tdata,
  // tdata: point_row, point_col, point_height, risk_total
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lmf_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  // tuser: is_low_point, frame_end
  output logic [lmf_pkg::OUT_TUSER_BITS-1:0]  out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [lmf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [lmf_pkg::CFG_BITS-1:0]        cfg_wdata
);
  import lmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Size register to index of the last column or row, saturated to range
  function automatic logic [CW-1:0] last_col_of(input logic [CFG_BITS-1:0] val);
    logic [31:0] vw;
    vw = 32'(val);
    if (vw < 32'd2) return CW'(1);
    else if (vw > 32'(MAX_WIDTH)) return CW'(MAX_WIDTH - 1);
    else return CW'(vw - 32'd1);
  endfunction

  function automatic logic [RW-1:0] last_row_of(input logic [CFG_BITS-1:0] val);
    logic [31:0] vw;
    vw = 32'(val);
    if (vw < 32'd2) return RW'(1);
    else if (vw > 32'(MAX_HEIGHT)) return RW'(MAX_HEIGHT - 1);
    else return RW'(vw - 32'd1);
  endfunction

  logic [CW-1:0]    last_col_r;
  logic [RW-1:0]    last_row_r;
  logic             take, res_valid;
  lmf_flags_t       res_flags;
  logic [COORD_BITS-1:0]  row_prev, row_cur, col_prev, col_cur;
  logic [SAMPLE_BITS-1:0] h_a, h_b, h_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= last_col_of(RESET_IMAGE_WIDTH);
      last_row_r <= last_row_of(RESET_IMAGE_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  last_col_r <= last_col_of(cfg_wdata);
        REG_IMAGE_HEIGHT: last_row_r <= last_row_of(cfg_wdata);
      endcase
    end
  end

  lmf_window #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .last_col  (last_col_r),
    .last_row  (last_row_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .take      (take),
    .res_valid (res_valid),
    .res_flags (res_flags),
    .row_prev  (row_prev),
    .row_cur   (row_cur),
    .col_prev  (col_prev),
    .col_cur   (col_cur),
    .h_a       (h_a),
    .h_b       (h_b),
    .h_c       (h_c)
  );

  lmf_emit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .res_valid  (res_valid),
    .take       (take),
    .res_flags  (res_flags),
    .row_prev   (row_prev),
    .row_cur    (row_cur),
    .col_prev   (col_prev),
    .col_cur    (col_cur),
    .h_a        (h_a),
    .h_b        (h_b),
    .h_c        (h_c),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // An empty input register must always take a request
  assert property (@(posedge clk) disable iff (!rst_n) !res_valid |-> in_tready)
    else $error("input stalled with empty input register");

  // The frame-end record is always the last one of its sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TU_FRAME_END] |-> out_tlast)
    else $error("frame-end record not last of run");

  // Every record is either a low point or a frame end, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[TU_IS_LOW] ^ out_tuser[TU_FRAME_END]))
    else $error("record kind flags inconsistent");

  // A sample is only passed on when the record queue can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !take |=> res_valid)
    else $error("sample lost from input register");

endmodule

>>> sim/lmf_low_point_checker.sv
// Scoreboard for the grid local-minimum finder: watches the size writes and both
// stream channels, predicts the low-point and frame-end records, and compares them.
// Depends on lmf_pkg for the field widths, the tuser bit positions and the register codes.
module lmf_low_point_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [7:0]                          in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [lmf_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  input  logic [lmf_pkg::OUT_TUSER_BITS-1:0]  out_tuser,
  input  logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [lmf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [lmf_pkg::CFG_BITS-1:0]        cfg_wdata,
  output int                                  n_fail,
  output int                                  n_pending
);
  import lmf_pkg::*;

  localparam int LINE_LEN = DEF_MAX_WIDTH;
  localparam int COL_LSB  = COORD_BITS;
  localparam int HGT_LSB  = 2 * COORD_BITS;
  localparam int RISK_LSB = HGT_LSB + HEIGHT_OUT_BITS;
  localparam logic [RISK_BITS-1:0] RISK_CEIL = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0]      row;
    logic [COORD_BITS-1:0]      col;
    logic [HEIGHT_OUT_BITS-1:0] hgt;
    logic                       low;
    logic [RISK_BITS-1:0]       risk;
    logic                       fe;
    logic                       last;
  } point_rec_t;

  point_rec_t expected_points[$];

  // shadow of the block's registers and window state
  logic [CFG_BITS-1:0]        width_reg, height_reg;
  logic [DEF_SAMPLE_BITS-1:0] line_above[LINE_LEN];
  logic [DEF_SAMPLE_BITS-1:0] line_cur[LINE_LEN];
  int                         row_pos, col_pos;
  logic [DEF_SAMPLE_BITS-1:0] left_above, left_cur;
  logic [RISK_BITS-1:0]       risk_sum;

  point_rec_t step_recs[3];
  int         step_n;
  int         mismatches;

  function automatic int clamp_size(input logic [CFG_BITS-1:0] v, input int maxv);
    if (v < 2) return 2;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic point_rec_t make_rec(input int r, input int c,
                                          input logic [3:0] h, input logic low,
                                          input logic [RISK_BITS-1:0] risk,
                                          input logic fe);
    point_rec_t p;
    p.row  = COORD_BITS'(r);
    p.col  = COORD_BITS'(c);
    p.hgt  = h;
    p.low  = low;
    p.risk = risk;
    p.fe   = fe;
    p.last = 1'b0;
    return p;
  endfunction

  task automatic restart_frame();
    row_pos    = 0;
    col_pos    = 0;
    left_above = '0;
    left_cur   = '0;
    risk_sum   = '0;
  endtask

  task automatic note_low(input int r, input int c, input logic [3:0] h);
    logic [RISK_BITS:0] s;
    s = {1'b0, risk_sum} + 1 + h;
    risk_sum = (s > {1'b0, RISK_CEIL}) ? RISK_CEIL : s[RISK_BITS-1:0];
    step_recs[step_n] = make_rec(r, c, h, 1'b1, risk_sum, 1'b0);
    step_n++;
  endtask

  task automatic predict_sample(input logic [DEF_SAMPLE_BITS-1:0] v);
    int w, h, r, c;
    logic [DEF_SAMPLE_BITS-1:0] mid, val;
    logic ok;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    step_n = 0;

    // sample one row up, same column, is decided by the new sample below it
    mid = line_cur[c];
    if (r >= 1) begin
      ok = v > mid;
      if (r >= 2 && !(line_above[c] > mid)) ok = 1'b0;
      if (c >= 1 && !(left_above > mid)) ok = 1'b0;
      if (c + 1 < w && !(line_cur[c + 1] > mid)) ok = 1'b0;
      if (ok) note_low(r - 1, c, mid);
    end
    line_above[c] = mid;

    // last row: previous column now has its right neighbour
    if (r == h - 1 && c >= 1) begin
      val = left_cur;
      ok = v > val && line_above[c - 1] > val;
      if (c >= 2 && !(line_cur[c - 2] > val)) ok = 1'b0;
      if (ok) note_low(r, c - 1, val);
    end

    if (r == h - 1 && c == w - 1) begin
      ok = line_above[c] > v;
      if (c >= 1 && !(left_cur > v)) ok = 1'b0;
      if (ok) note_low(r, c, v);
      step_recs[step_n] = make_rec(0, 0, '0, 1'b0, risk_sum, 1'b1);
      step_n++;
      risk_sum = '0;
    end

    line_cur[c] = v;
    left_above  = mid;
    left_cur    = v;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end

    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_recs[i].last = 1'b1;
      expected_points.push_back(step_recs[i]);
    end
  endtask

  task automatic report_miss(input point_rec_t want, input point_rec_t got,
                             input bit have_want);
    mismatches++;
    if (mismatches <= 10) begin
      if (!have_want)
        $display("unexpected record: row %0d col %0d h %0d low %0b risk %0d fe %0b last %0b",
                 got.row, got.col, got.hgt, got.low, got.risk, got.fe, got.last);
      else
        $display("record mismatch: want row %0d col %0d h %0d low %0b risk %0d fe %0b last %0b, got row %0d col %0d h %0d low %0b risk %0d fe %0b last %0b",
                 want.row, want.col, want.hgt, want.low, want.risk, want.fe, want.last,
                 got.row, got.col, got.hgt, got.low, got.risk, got.fe, got.last);
    end
  endtask

  initial begin
    mismatches = 0;
    n_fail     = 0;
    n_pending  = 0;
  end

  always @(posedge clk) begin
    point_rec_t got, want;
    if (!rst_n) begin
      width_reg  = RESET_IMAGE_WIDTH;
      height_reg = RESET_IMAGE_HEIGHT;
      for (int i = 0; i < LINE_LEN; i++) begin
        line_above[i] = '0;
        line_cur[i]   = '0;
      end
      restart_frame();
      expected_points.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.row  = out_tdata[COL_LSB-1:0];
        got.col  = out_tdata[HGT_LSB-1:COL_LSB];
        got.hgt  = out_tdata[RISK_LSB-1:HGT_LSB];
        got.risk = out_tdata[RISK_LSB+RISK_BITS-1:RISK_LSB];
        got.low  = out_tuser[TU_IS_LOW];
        got.fe   = out_tuser[TU_FRAME_END];
        got.last = out_tlast;
        if (expected_points.size() == 0) begin
          report_miss(got, got, 1'b0);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) report_miss(want, got, 1'b1);
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_IMAGE_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
        restart_frame();
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata[DEF_SAMPLE_BITS-1:0]);
    end
    n_pending <= expected_points.size();
    n_fail    <= mismatches;
  end

endmodule

>>> sim/grid_local_minimum_finder_tb.sv
// Stimulus and verdict for grid_local_minimum_finder: height-map frames of many sizes,
// random stream stalls and one long output hold-off. Uses lmf_pkg and lmf_low_point_checker.
module grid_local_minimum_finder_tb;
  import lmf_pkg::*;

  localparam int IN_TDATA_BITS = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 18;

  logic clk;
  logic rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [IN_TDATA_BITS-1:0]   in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]  out_tdata;
  logic [OUT_TUSER_BITS-1:0]  out_tuser;
  logic                       out_tlast;
  logic                       cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   cfg_addr = REG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0]        cfg_wdata = '0;

  int   fail_count, pending_count;
  int   tx_idle_pct = 37;
  int   rx_idle_pct = 62;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int   cycle_count = 0;

  grid_local_minimum_finder uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  lmf_low_point_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .n_fail(fail_count), .n_pending(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

  // long receiver hold-off while the sender keeps requesting
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // one sample request; padding bits above the sample are random
  task automatic push_sample(input logic [3:0] h);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'($urandom_range(15)), h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // samples without a record may still sit in the pipeline
    repeat (10) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [7:0] w, input logic [7:0] h);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_size();
    if ($urandom_range(7) == 0) return 8'($urandom_range(1));
    return 8'($urandom_range(6, 2));
  endfunction

  initial begin
    logic [7:0] w_raw, h_raw;
    int w, h, n_items, top_h;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes (100 x 100): just over two rows of samples
    for (int i = 0; i < 210; i++) push_sample(4'($urandom_range(15)));

    // corner low point at the top left
    set_sizes(8'd2, 8'd2);
    push_sample(4'd0); push_sample(4'd15); push_sample(4'd15); push_sample(4'd15);
    // flat frame: ties never count
    repeat (4) push_sample(4'd7);
    // two low points and the summary from the final sample
    push_sample(4'd9); push_sample(4'd1); push_sample(4'd1); push_sample(4'd9);
    set_sizes(8'd3, 8'd3);
    for (int i = 0; i < 9; i++) push_sample((i == 4) ? 4'd0 : 4'd9);
    // sizes below range saturate to 2; final sample itself is the low point
    set_sizes(8'd1, 8'd0);
    push_sample(4'd15); push_sample(4'd15); push_sample(4'd15); push_sample(4'd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES / 3) begin
        tx_idle_pct = 62;
        rx_idle_pct = 37;
      end else if (p == 2 * RAND_PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == RAND_PHASES / 3) begin
        w_raw = 8'd1;
        h_raw = 8'd128;
      end else if (p == 2 * RAND_PHASES / 3) begin
        w_raw = 8'd255;
        h_raw = 8'd129;
      end else begin
        w_raw = pick_size();
        h_raw = pick_size();
      end
      w = (w_raw < 2) ? 2 : ((w_raw > 128) ? 128 : int'(w_raw));
      h = (h_raw < 2) ? 2 : ((h_raw > 128) ? 128 : int'(h_raw));
      if (w * h > 64) n_items = w * h;
      else n_items = $urandom_range(2, 1) * w * h;
      // some phases stop mid-frame so the next write restarts it
      if ($urandom_range(3) == 0) n_items += $urandom_range(w * h - 1);
      // narrow height ranges give plenty of ties
      top_h = ($urandom_range(1) == 0) ? 15 : 3;
      set_sizes(w_raw, h_raw);
      if (p == 2 * RAND_PHASES / 3) hold_go <= 1'b1;
      for (int i = 0; i < n_items; i++) push_sample(4'($urandom_range(top_h)));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
